// ===== src/spm_pkg.sv =====
// ----------------------------------------------------------------------------
// spm_pkg - shared types and constants of the servo pulse mixer
// Beat structs, register indexes, divider lane request and sizing constants.
// ----------------------------------------------------------------------------
package spm_pkg;

  // configuration register indexes
  typedef enum logic [2:0] {
    CFG_STICK_DEADZONE   = 3'd0,
    CFG_STICK_FULL_SCALE = 3'd1,
    CFG_TRIGGER_DEADZONE = 3'd2,
    CFG_AILERON_DIFF     = 3'd3,
    CFG_INVERT_MASK      = 3'd4
  } cfg_idx_t;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 15;

  // divider lanes
  localparam int LANE_ROLL  = 0;
  localparam int LANE_PITCH = 1;
  localparam int LANE_YAW   = 2;
  localparam int LANE_THR   = 3;
  localparam int N_LANES    = 4;

  // quotient bits, bits resolved per divider stage, stage count
  localparam int QUO_W       = 15;
  localparam int DIV_BPS     = 3;
  localparam int DIV_STAGES  = QUO_W / DIV_BPS;

  // magnitude scale: 16'h8000 is one
  localparam int MAG_W = 16;
  localparam logic [MAG_W-1:0] MAG_ONE = 16'h8000;

  // pulse products and constants
  localparam int PROD_W = 25;
  localparam int PULSE_W = 11;
  localparam logic [PULSE_W-1:0] PULSE_MIN = 11'd1000;
  localparam logic [PULSE_W-1:0] PULSE_MID = 11'd1500;
  localparam logic [PULSE_W-1:0] PULSE_MAX = 11'd2000;

  typedef struct packed {
    logic signed [15:0] stick_left_x;
    logic signed [15:0] stick_left_y;
    logic signed [15:0] stick_right_x;
    logic        [7:0]  right_trigger;
  } in_beat_t;

  typedef struct packed {
    logic [10:0] aileron_left_pulse;
    logic [10:0] aileron_right_pulse;
    logic [10:0] elevator_pulse;
    logic [10:0] rudder_pulse;
    logic [10:0] throttle_pulse;
  } out_beat_t;

  // side flags that ride along with a division
  typedef struct packed {
    logic nz;   // excess beyond deadzone is non-zero
    logic sat;  // result saturates at one
    logic neg;  // raw sign of the axis
  } div_aux_t;

  typedef struct packed {
    logic [QUO_W-1:0] num;  // always below den
    logic [QUO_W-1:0] den;
    div_aux_t         aux;
  } div_req_t;

endpackage

// ===== src/spm_div.sv =====
// ----------------------------------------------------------------------------
// spm_div - pipelined restoring divider, one lane
// Gives floor(num * 2^15 / den) for num < den, a few quotient bits per stage.
// ----------------------------------------------------------------------------
module spm_div (
  input  logic                       clk,
  input  logic                       en,
  input  spm_pkg::div_req_t          in_req,
  output logic [spm_pkg::QUO_W-1:0]  out_quo,
  output spm_pkg::div_aux_t          out_aux
);

  localparam int QW = spm_pkg::QUO_W;
  localparam int NS = spm_pkg::DIV_STAGES;

  logic [QW-1:0]       rem_r [NS];
  logic [QW-1:0]       quo_r [NS];
  logic [QW-1:0]       den_r [NS];
  spm_pkg::div_aux_t   aux_r [NS];

  for (genvar k = 0; k < NS; k++) begin : g_stg
    logic [QW-1:0]     rem_src;
    logic [QW-1:0]     quo_src;
    logic [QW-1:0]     den_src;
    spm_pkg::div_aux_t aux_src;
    logic [QW-1:0]     rem_nxt;
    logic [QW-1:0]     quo_nxt;

    // stage source
    if (k == 0) begin : g_first
      assign rem_src = in_req.num;
      assign quo_src = '0;
      assign den_src = in_req.den;
      assign aux_src = in_req.aux;
    end else begin : g_next
      assign rem_src = rem_r[k-1];
      assign quo_src = quo_r[k-1];
      assign den_src = den_r[k-1];
      assign aux_src = aux_r[k-1];
    end

    // shift, trial subtract, one quotient bit per step
    always_comb begin
      logic [QW:0]   t;
      logic [QW-1:0] r;
      logic [QW-1:0] q;
      r = rem_src;
      q = quo_src;
      for (int i = 0; i < spm_pkg::DIV_BPS; i++) begin
        t = {r, 1'b0};
        if (t >= {1'b0, den_src}) begin
          t = t - {1'b0, den_src};
          q = {q[QW-2:0], 1'b1};
        end else begin
          q = {q[QW-2:0], 1'b0};
        end
        r = t[QW-1:0];
      end
      rem_nxt = r;
      quo_nxt = q;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= rem_nxt;
        quo_r[k] <= quo_nxt;
        den_r[k] <= den_src;
        aux_r[k] <= aux_src;
      end
    end
  end

  assign out_quo = quo_r[NS-1];
  assign out_aux = aux_r[NS-1];

endmodule

// ===== src/gamepad_to_servo_pulse_mixer.sv =====
// ----------------------------------------------------------------------------
// gamepad_to_servo_pulse_mixer - gamepad sample to five servo pulse widths
// Deadzone, rescale, differential ailerons and pulse conversion, pipelined.
// ----------------------------------------------------------------------------
// Usage:
//   in_* carries one gamepad sample a beat (three stick axes and the trigger),
//   out_* one beat of five pulse widths in microseconds (1000..2000).
//   Both channels use valid/ready. cfg_* is a plain write port, taken
//   whenever cfg_wr_en is high; write it only while the pipe is empty.
//   An accepted input beat passes one front-end stage, five divider
//   stages (three quotient bits each), an aileron scaling stage, a pulse
//   multiply stage and the output register before it reaches out_valid.
//   Throughput is one beat per cycle when not stalled, set by the pipelined dividers.
//   When the receiver stalls with a beat waiting, the whole pipe holds and
//   in_ready drops in the same cycle; nothing is dropped or repeated.
//   Reset empties the pipe and loads the default register values
//   (deadzone 3500, full scale 27000, trigger deadzone 15, diff 102,
//   pitch inverted).
// ----------------------------------------------------------------------------
module gamepad_to_servo_pulse_mixer (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  spm_pkg::in_beat_t                  in_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output spm_pkg::out_beat_t                 out_data,
  input  logic                               cfg_wr_en,
  input  logic [spm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [spm_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  localparam int QW = spm_pkg::QUO_W;
  localparam int MW = spm_pkg::MAG_W;
  localparam int PW = spm_pkg::PROD_W;
  localparam int NL = spm_pkg::N_LANES;
  localparam int NS = spm_pkg::DIV_STAGES;

  // configuration registers
  logic [14:0] stick_dz_r;
  logic [14:0] stick_fs_r;
  logic [7:0]  trig_dz_r;
  logic [8:0]  ail_diff_r;
  logic [2:0]  inv_mask_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stick_dz_r <= 15'd3500;
      stick_fs_r <= 15'd27000;
      trig_dz_r  <= 8'd15;
      ail_diff_r <= 9'd102;
      inv_mask_r <= 3'd2;
    end else if (cfg_wr_en) begin
      case (spm_pkg::cfg_idx_t'(cfg_index))
        spm_pkg::CFG_STICK_DEADZONE:   stick_dz_r <= cfg_wdata;
        spm_pkg::CFG_STICK_FULL_SCALE: stick_fs_r <= cfg_wdata;
        spm_pkg::CFG_TRIGGER_DEADZONE: trig_dz_r  <= cfg_wdata[7:0];
        spm_pkg::CFG_AILERON_DIFF:     ail_diff_r <= cfg_wdata[8:0];
        spm_pkg::CFG_INVERT_MASK:      inv_mask_r <= cfg_wdata[2:0];
        default: ;
      endcase
    end
  end

  // whole pipe advances unless the output beat is held
  logic adv;
  logic out_valid_r;
  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv;

  // stick deadzone and divider request
  function automatic spm_pkg::div_req_t shape_stick(input logic [15:0] raw,
                                                    input logic [14:0] dz,
                                                    input logic [14:0] fs);
    logic [15:0]       mag;
    logic [15:0]       excess;
    logic [14:0]       span;
    logic              nz;
    logic              sat;
    spm_pkg::div_req_t r;
    mag    = raw[15] ? (16'd0 - raw) : raw;
    excess = (mag >= {1'b0, dz}) ? (mag - {1'b0, dz}) : 16'd0;
    span   = fs - dz;
    nz     = (excess != 16'd0);
    sat    = nz && ((fs <= dz) || (excess >= {1'b0, span}));
    r.aux.nz  = nz;
    r.aux.sat = sat;
    r.aux.neg = raw[15];
    if (nz && !sat) begin
      r.num = excess[14:0];
      r.den = span;
    end else begin
      r.num = '0;
      r.den = 15'd1;
    end
    return r;
  endfunction

  // trigger deadzone and divider request
  function automatic spm_pkg::div_req_t shape_trig(input logic [7:0] raw,
                                                   input logic [7:0] dz);
    logic [7:0]        excess;
    logic [7:0]        span;
    logic              nz;
    spm_pkg::div_req_t r;
    excess = (raw >= dz) ? (raw - dz) : 8'd0;
    span   = 8'd255 - dz;
    nz     = (excess != 8'd0);
    r.aux.nz  = nz;
    r.aux.sat = nz && (excess == span);
    r.aux.neg = 1'b0;
    if (nz && !r.aux.sat) begin
      r.num = {7'd0, excess};
      r.den = {7'd0, span};
    end else begin
      r.num = '0;
      r.den = 15'd1;
    end
    return r;
  endfunction

  // front-end stage
  spm_pkg::div_req_t req_nxt [NL];
  spm_pkg::div_req_t req_r   [NL];
  logic              s0_vld_r;

  assign req_nxt[spm_pkg::LANE_ROLL]  = shape_stick(in_data.stick_left_x,
                                                    stick_dz_r, stick_fs_r);
  assign req_nxt[spm_pkg::LANE_PITCH] = shape_stick(in_data.stick_left_y,
                                                    stick_dz_r, stick_fs_r);
  assign req_nxt[spm_pkg::LANE_YAW]   = shape_stick(in_data.stick_right_x,
                                                    stick_dz_r, stick_fs_r);
  assign req_nxt[spm_pkg::LANE_THR]   = shape_trig(in_data.right_trigger, trig_dz_r);

  always_ff @(posedge clk) begin
    if (adv) begin
      req_r <= req_nxt;
    end
  end

  // dividers, one per lane
  logic [QW-1:0]     quo   [NL];
  spm_pkg::div_aux_t qaux  [NL];

  for (genvar l = 0; l < NL; l++) begin : g_lane
    spm_div u_div (
      .clk     (clk),
      .en      (adv),
      .in_req  (req_r[l]),
      .out_quo (quo[l]),
      .out_aux (qaux[l])
    );
  end

  // valid bits alongside the divider stages
  logic dv_vld_r [NS];
  logic p1_vld_r;
  logic p2_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r    <= 1'b0;
      dv_vld_r    <= '{default: 1'b0};
      p1_vld_r    <= 1'b0;
      p2_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      s0_vld_r    <= in_valid;
      dv_vld_r[0] <= s0_vld_r;
      for (int k = 1; k < NS; k++) begin
        dv_vld_r[k] <= dv_vld_r[k-1];
      end
      p1_vld_r    <= dv_vld_r[NS-1];
      p2_vld_r    <= p1_vld_r;
      out_valid_r <= p2_vld_r;
    end
  end

  // magnitudes, signs and aileron scaling product
  logic [MW-1:0] mag   [NL];
  logic [2:0]    sneg;
  logic [8:0]    keep;
  logic [PW-1:0] rprod_nxt;

  always_comb begin
    for (int l = 0; l < NL; l++) begin
      mag[l] = qaux[l].sat ? spm_pkg::MAG_ONE : {1'b0, quo[l]};
    end
    for (int a = 0; a < 3; a++) begin
      sneg[a] = qaux[a].nz && (qaux[a].neg ^ inv_mask_r[a]);
    end
    keep      = 9'd256 - (ail_diff_r[8] ? 9'd256 : ail_diff_r);
    rprod_nxt = {{(PW-MW){1'b0}}, mag[spm_pkg::LANE_ROLL]} * {{(PW-9){1'b0}}, keep};
  end

  logic [MW-1:0] p1_mag_r [NL];
  logic [2:0]    p1_neg_r;
  logic [PW-1:0] p1_rprod_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      p1_mag_r   <= mag;
      p1_neg_r   <= sneg;
      p1_rprod_r <= rprod_nxt;
    end
  end

  // aileron split and pulse multiplies
  logic [MW-1:0] scaled;
  logic [MW-1:0] lm;
  logic [MW-1:0] rgm;
  logic          rn;
  logic [PW-1:0] prod_nxt [5];
  logic [3:0]    pneg_nxt;

  always_comb begin
    rn     = p1_neg_r[0];
    scaled = p1_rprod_r[MW+7:8];
    lm     = rn ? p1_mag_r[spm_pkg::LANE_ROLL] : scaled;
    rgm    = rn ? scaled : p1_mag_r[spm_pkg::LANE_ROLL];
    prod_nxt[0] = {{(PW-MW){1'b0}}, lm}  * 25'd500;
    prod_nxt[1] = {{(PW-MW){1'b0}}, rgm} * 25'd500;
    prod_nxt[2] = {{(PW-MW){1'b0}}, p1_mag_r[spm_pkg::LANE_PITCH]} * 25'd500;
    prod_nxt[3] = {{(PW-MW){1'b0}}, p1_mag_r[spm_pkg::LANE_YAW]}   * 25'd500;
    prod_nxt[4] = {{(PW-MW){1'b0}}, p1_mag_r[spm_pkg::LANE_THR]}   * 25'd1000;
    pneg_nxt[0] = rn;
    pneg_nxt[1] = !rn && (p1_mag_r[spm_pkg::LANE_ROLL] != '0);
    pneg_nxt[2] = p1_neg_r[1];
    pneg_nxt[3] = p1_neg_r[2];
  end

  logic [PW-1:0] p2_prod_r [5];
  logic [3:0]    p2_neg_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      p2_prod_r <= prod_nxt;
      p2_neg_r  <= pneg_nxt;
    end
  end

  // clamp to the servo range
  function automatic logic [10:0] clamp_pulse(input logic [10:0] p);
    if (p < spm_pkg::PULSE_MIN) return spm_pkg::PULSE_MIN;
    if (p > spm_pkg::PULSE_MAX) return spm_pkg::PULSE_MAX;
    return p;
  endfunction

  // stick pulse: floor of 1500 + v*500, rounding away below centre
  function automatic logic [10:0] stick_pulse(input logic neg, input logic [PW-1:0] prod);
    logic [PW:0]  up;
    logic [10:0]  p;
    up = {1'b0, prod} + 26'd32767;
    if (neg) begin
      p = spm_pkg::PULSE_MID - up[PW:15];
    end else begin
      p = spm_pkg::PULSE_MID + {1'b0, prod[PW-1:15]};
    end
    return clamp_pulse(p);
  endfunction

  spm_pkg::out_beat_t out_nxt;
  spm_pkg::out_beat_t out_data_r;

  always_comb begin
    out_nxt.aileron_left_pulse  = stick_pulse(p2_neg_r[0], p2_prod_r[0]);
    out_nxt.aileron_right_pulse = stick_pulse(p2_neg_r[1], p2_prod_r[1]);
    out_nxt.elevator_pulse      = stick_pulse(p2_neg_r[2], p2_prod_r[2]);
    out_nxt.rudder_pulse        = stick_pulse(p2_neg_r[3], p2_prod_r[3]);
    out_nxt.throttle_pulse      = clamp_pulse(spm_pkg::PULSE_MIN
                                              + {1'b0, p2_prod_r[4][PW-1:15]});
  end

  // output register
  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== src/spm_checker.sv =====
// ----------------------------------------------------------------------------
// spm_checker - port-level checks of the servo pulse mixer
// Watches stall behaviour, reset, the range of every output beat and aileron opposition.
// ----------------------------------------------------------------------------
module spm_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_ready,
  input  logic               out_valid,
  input  logic               out_ready,
  input  spm_pkg::out_beat_t out_data
);

  // a held output beat stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output beat changed while stalled");

  // reset leaves no output beat valid
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // input side stalls exactly when the output beat is held
  a_ready_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready == (!out_valid || out_ready))
    else $error("in_ready does not follow output stall");

  // every pulse lies in the servo range
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |->
      out_data.aileron_left_pulse  >= 11'd1000 && out_data.aileron_left_pulse  <= 11'd2000 &&
      out_data.aileron_right_pulse >= 11'd1000 && out_data.aileron_right_pulse <= 11'd2000 &&
      out_data.elevator_pulse      >= 11'd1000 && out_data.elevator_pulse      <= 11'd2000 &&
      out_data.rudder_pulse        >= 11'd1000 && out_data.rudder_pulse        <= 11'd2000 &&
      out_data.throttle_pulse      >= 11'd1000 && out_data.throttle_pulse      <= 11'd2000)
    else $error("pulse out of range");

  // ailerons never both deflect below centre
  a_ail_opposed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.aileron_left_pulse < 11'd1500 |->
      out_data.aileron_right_pulse >= 11'd1500)
    else $error("ailerons deflect together");

endmodule

bind gamepad_to_servo_pulse_mixer spm_checker u_spm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
